/* src/sorted_priority_queue_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent checks on the core clock; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SPQ_ASSERT(name, prop, msg)
`define SPQ_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

/* src/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   typedef logic [2:0] spq_req_code_type;
   typedef logic [6:0] spq_cnt7_type;

   localparam spq_req_code_type REQ_INSERT = 3'd0;
   localparam spq_req_code_type REQ_REMOVE = 3'd1;
   localparam spq_req_code_type REQ_EXISTS = 3'd2;
   localparam spq_req_code_type REQ_FETCH  = 3'd3;
   localparam spq_req_code_type REQ_PEEK   = 3'd4;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } spq_status_type;

   localparam spq_cnt7_type CAP_RESET = 7'd64;

   // Broadcast command to every cell
   typedef struct packed {
      logic insert;     // place new entry, shift tail up
      logic remove;     // drop first key/tag match, shift tail down
      logic pop_head;   // drop cell 0, shift everything down
   } spq_op_type;

endpackage

/* src/spq_req_if.sv */
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: valid/ready with operation code, key and tag.
// ----------------------------------------------------------------------------
interface spq_req_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16
);
   import spq_pkg::*;

   logic                valid;
   logic                ready;
   spq_req_code_type    req_type;
   logic [KEY_BITS-1:0] key;
   logic [TAG_BITS-1:0] tag;

   modport source (output valid, req_type, key, tag, input ready);
   modport sink   (input valid, req_type, key, tag, output ready);
endinterface

/* src/spq_rsp_if.sv */
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: valid/ready with status, head entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16
);
   import spq_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [KEY_BITS-1:0] head_key;
   logic [TAG_BITS-1:0] head_tag;
   spq_cnt7_type        occupancy;

   modport source (output valid, status, head_key, head_tag, occupancy, input ready);
   modport sink   (input valid, status, head_key, head_tag, occupancy, output ready);
endinterface

/* src/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store: compares the broadcast key/tag and shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::spq_op_type op,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [TAG_BITS-1:0] left_tag,
   input  logic                left_used,
   input  logic                left_lt,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [TAG_BITS-1:0] right_tag,
   input  logic                right_used,
   input  logic                hit_in,
   output logic [KEY_BITS-1:0] key,
   output logic [TAG_BITS-1:0] tag,
   output logic                used,
   output logic                lt,
   output logic                hit_out
);
   import spq_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                used_ff, used_in;
   logic                match;

   assign lt      = used_ff && (key_ff < new_key);
   assign match   = used_ff && (key_ff == new_key) && (tag_ff == new_tag);
   assign hit_out = hit_in || match;

   always_comb begin
      key_in  = key_ff;
      tag_in  = tag_ff;
      used_in = used_ff;
      if (op.insert && !lt) begin
         if (left_lt) begin
            key_in  = new_key;
            tag_in  = new_tag;
            used_in = 1'b1;
         end else begin
            key_in  = left_key;
            tag_in  = left_tag;
            used_in = left_used;
         end
      end else if (op.pop_head || (op.remove && hit_out)) begin
         key_in  = right_key;
         tag_in  = right_tag;
         used_in = right_used;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign key  = key_ff;
   assign tag  = tag_ff;
   assign used = used_ff;
endmodule

/* src/sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue of (key, tag) entries kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// The queue holds up to MAX_ENTRIES entries in ascending unsigned key order,
// cell 0 being the head. Requests: insert (refused with FULL once the count
// reaches min(capacity, MAX_ENTRIES); a new entry goes in front of equal
// keys), remove of a key/tag match, existence test, fetch head and peek head.
// Every request gives exactly one response item carrying a status, the head
// entry for fetch/peek (zero otherwise) and the occupancy after the request.
// Rate: one item per clock. All cells compare the broadcast key and tag in
// the same cycle and shift one place in either direction, so each request
// finishes in the cycle it is accepted; the response sits in one output
// register and the request side stalls only while that register holds an
// item not yet taken. Capacity is written through csr_wr_en/csr_wr_data and
// must only change while the queue is idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   spq_req_if.sink               req_ch,
   spq_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  spq_pkg::spq_cnt7_type csr_wr_data
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // cell row wiring
   logic [KEY_BITS-1:0] key_w [MAX_ENTRIES];
   logic [TAG_BITS-1:0] tag_w [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] used_w;
   logic [MAX_ENTRIES-1:0] lt_w;
   logic [MAX_ENTRIES-1:0] hit_w;

   spq_op_type     op;
   spq_cnt7_type   capacity_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   spq_status_type      status_ff, status_in;
   logic [KEY_BITS-1:0] head_key_ff, head_key_in;
   logic [TAG_BITS-1:0] head_tag_ff, head_tag_in;
   spq_cnt7_type        occ_ff;

   logic req_ready, req_fire;
   logic full, empty, found;

   assign req_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   // limit is min(capacity, MAX_ENTRIES)
   assign full  = (count_ff >= CNT_W'(MAX_ENTRIES)) ||
                  (CMP_W'(count_ff) >= CMP_W'(capacity_ff));
   assign empty = (count_ff == '0);
   assign found = hit_w[MAX_ENTRIES-1];   // hit chain end: any key/tag match

   // ---- cell row ----------------------------------------------------------
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0] l_key, r_key;
      logic [TAG_BITS-1:0] l_tag, r_tag;
      logic                l_used, l_lt, r_used, h_in;

      if (i == 0) begin : g_first
         // head cell: a new entry always fits in front of it
         assign l_key  = '0;
         assign l_tag  = '0;
         assign l_used = 1'b0;
         assign l_lt   = 1'b1;
         assign h_in   = 1'b0;
      end else begin : g_mid
         assign l_key  = key_w[i-1];
         assign l_tag  = tag_w[i-1];
         assign l_used = used_w[i-1];
         assign l_lt   = lt_w[i-1];
         assign h_in   = hit_w[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_last
         assign r_key  = '0;
         assign r_tag  = '0;
         assign r_used = 1'b0;
      end else begin : g_inner
         assign r_key  = key_w[i+1];
         assign r_tag  = tag_w[i+1];
         assign r_used = used_w[i+1];
      end

      spq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_key    (req_ch.key),
         .new_tag    (req_ch.tag),
         .left_key   (l_key),
         .left_tag   (l_tag),
         .left_used  (l_used),
         .left_lt    (l_lt),
         .right_key  (r_key),
         .right_tag  (r_tag),
         .right_used (r_used),
         .hit_in     (h_in),
         .key        (key_w[i]),
         .tag        (tag_w[i]),
         .used       (used_w[i]),
         .lt         (lt_w[i]),
         .hit_out    (hit_w[i])
      );
   end

   // ---- request decode ----------------------------------------------------
   always_comb begin
      op          = '0;
      status_in   = ST_OK;
      head_key_in = '0;
      head_tag_in = '0;
      count_in    = count_ff;
      unique case (req_ch.req_type) inside
         REQ_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op.insert = req_fire;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_REMOVE, REQ_EXISTS: begin
            if (!found) begin
               status_in = ST_NOT_FOUND;
            end else if (req_ch.req_type == REQ_REMOVE) begin
               op.remove = req_fire;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         REQ_FETCH, REQ_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_key_in = key_w[0];
               head_tag_in = tag_w[0];
               if (req_ch.req_type == REQ_FETCH) begin
                  op.pop_head = req_fire;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            // undefined codes: no change, status OK
         end
      endcase
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ch.ready);

   // ---- registers ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff   <= status_in;
         head_key_ff <= head_key_in;
         head_tag_ff <= head_tag_in;
         occ_ff      <= spq_cnt7_type'(count_in);
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.head_key  = head_key_ff;
   assign rsp_ch.head_tag  = head_tag_ff;
   assign rsp_ch.occupancy = occ_ff;

   // ---- checks ------------------------------------------------------------
   // occupied cells form a prefix of the row, as many as the count says
   `SPQ_ASSERT(a_used_prefix, (used_w & (used_w + MAX_ENTRIES'(1))) == '0,
               "used cells not a prefix")
   `SPQ_ASSERT(a_used_count, $countones(used_w) == int'(count_ff),
               "used cells differ from count")
   `SPQ_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_ENTRIES), "count above store size")
   // a refused insert must leave the store untouched
   `SPQ_ASSERT_NEXT(a_full_hold, req_fire && req_ch.req_type == REQ_INSERT && full,
                    count_ff == $past(count_ff) && used_w == $past(used_w),
                    "refused insert changed store")
   // the request side only stalls behind an untaken response
   `SPQ_ASSERT(a_stall_cause, !req_ready |-> rsp_valid_ff, "stall without pending response")

endmodule

/* tb/sorted_priority_queue_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Self-checking bench for the sorted priority queue core. A directed table
// covers the empty, full and extreme-key corners. Random phases follow,
// each at its own capacity and insert/remove mix. Every response item is
// checked against a mirror of the sorted store, or a directed row's own values.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   // request codes the core must ignore (no state change, status ok)
   localparam spq_req_code_type REQ_UNDEF_LO  = 3'd5;
   localparam spq_req_code_type REQ_UNDEF_MID = 3'd6;
   localparam spq_req_code_type REQ_UNDEF_HI  = 3'd7;

   localparam int STORE_SLOTS = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;     // receiver back-pressure stretch, cycles
   localparam int NUM_PHASES  = 12;
   localparam int PHASE_ITEMS = 155;
   localparam int TAIL_ITEMS  = 150;    // no idling on either side for these
   localparam int NUM_DIR     = 26;

   typedef struct {
      spq_status_type status;
      logic [31:0]    head_key;
      logic [15:0]    head_tag;
      spq_cnt7_type   occupancy;
   } queue_result_type;

   // one row of the directed table; a capacity row carries the value in key
   typedef struct {
      bit               is_cap;
      spq_req_code_type op;
      logic [31:0]      key;
      logic [15:0]      tag;
      bit               typed;
      spq_status_type   status;
      logic [31:0]      head_key;
      logic [15:0]      head_tag;
      spq_cnt7_type     occupancy;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   spq_cnt7_type csr_wr_data;

   spq_req_if #(.KEY_BITS(32), .TAG_BITS(16)) req_ch ();
   spq_rsp_if #(.KEY_BITS(32), .TAG_BITS(16)) rsp_ch ();

   sorted_priority_queue_core #(
      .MAX_ENTRIES (STORE_SLOTS),
      .KEY_BITS    (32),
      .TAG_BITS    (16)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Mirror of the sorted store: slot 0 is the head, slots 0..count-1 in use
   // ------------------------------------------------------------------------
   logic [31:0] mirror_key [STORE_SLOTS];
   logic [15:0] mirror_tag [STORE_SLOTS];
   int          mirror_count = 0;
   int          mirror_cap   = 64;

   queue_result_type expected_replies [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;

   // flow control knobs shared by the two sides
   int  idle_pct      = 0;
   bit  quiet_tail    = 1'b0;
   bit  hold_request  = 1'b0;
   bit  hold_active   = 1'b0;

   // close the gap at pos, tail moves one slot toward the head
   function automatic void mirror_drop(int pos);
      int i;
      for (i = pos; i + 1 < mirror_count; i++) begin
         mirror_key[i] = mirror_key[i + 1];
         mirror_tag[i] = mirror_tag[i + 1];
      end
      mirror_count--;
   endfunction

   // apply one request to the mirror and return the response it should give
   function automatic queue_result_type queue_apply(spq_req_code_type op,
                                                    logic [31:0] k, logic [15:0] t);
      queue_result_type r;
      int            lim;
      int            pos;
      int            i;
      bit            hit;
      r.status   = ST_OK;
      r.head_key = '0;
      r.head_tag = '0;
      // capacity above the store size is clipped to the store
      lim = (mirror_cap < STORE_SLOTS) ? mirror_cap : STORE_SLOTS;
      case (op) inside
         REQ_INSERT: begin
            if (mirror_count >= lim) begin
               r.status = ST_FULL;
            end else begin
               // lands in front of any equal keys
               pos = 0;
               while (pos < mirror_count && mirror_key[pos] < k) pos++;
               for (i = mirror_count; i > pos; i--) begin
                  mirror_key[i] = mirror_key[i - 1];
                  mirror_tag[i] = mirror_tag[i - 1];
               end
               mirror_key[pos] = k;
               mirror_tag[pos] = t;
               mirror_count++;
            end
         end
         REQ_REMOVE, REQ_EXISTS: begin
            // first (lowest-placed) key+tag match wins
            hit = 1'b0;
            pos = 0;
            for (i = 0; i < mirror_count; i++) begin
               if (!hit && mirror_key[i] == k && mirror_tag[i] == t) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
            if (!hit) r.status = ST_NOT_FOUND;
            else if (op == REQ_REMOVE) mirror_drop(pos);
         end
         REQ_FETCH, REQ_PEEK: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.head_key = mirror_key[0];
               r.head_tag = mirror_tag[0];
               if (op == REQ_FETCH) mirror_drop(0);
            end
         end
         default: ;
      endcase
      r.occupancy = mirror_count[6:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Offer one item and return on the edge that accepts it. valid stays high
   // afterwards; the caller either offers the next item in the same step or
   // drops valid.
   task automatic send_item(spq_req_code_type op, logic [31:0] k, logic [15:0] t);
      if (!quiet_tail && !hold_active && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.key      <= k;
      req_ch.tag      <= t;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // capacity changes only with the queue idle: nothing in flight, nothing owed
   task automatic write_capacity(spq_cnt7_type cap);
      req_ch.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror_cap = cap;
   endtask

   function automatic logic [31:0] rand_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 32'($urandom_range(0, 15));  // dense: equal keys
      if (sel == 4) begin
         case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [15:0] rand_tag();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 3));
      return 16'($urandom_range(0, 65535));
   endfunction

   // random request; removes and lookups usually aim at a stored entry
   task automatic pick_request(int ins_pct, output spq_req_code_type op,
                               output logic [31:0] k, output logic [15:0] t);
      int r;
      int slot;
      r = $urandom_range(0, 99);
      k = rand_key();
      t = rand_tag();
      if (r < ins_pct) begin
         op = REQ_INSERT;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 30)      op = REQ_REMOVE;
         else if (r < 50) op = REQ_EXISTS;
         else if (r < 70) op = REQ_FETCH;
         else if (r < 90) op = REQ_PEEK;
         else
            op = spq_req_code_type'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
         if ((op == REQ_REMOVE || op == REQ_EXISTS) && mirror_count > 0
             && $urandom_range(0, 9) < 6) begin
            slot = $urandom_range(0, mirror_count - 1);
            k = mirror_key[slot];
            t = mirror_tag[slot];
         end
      end
   endtask

   // directed table: after-reset, extreme and error rows carry the response
   dir_row_type dir_tab [NUM_DIR];

   // capacity and insert share per random phase
   int phase_cap [NUM_PHASES] = '{127, 64, 1, 0, 2, 64, 63, 17, 5, 100, 64, 0};
   int phase_ins [NUM_PHASES] = '{80, 80, 50, 50, 60, 15, 70, 50, 40, 60, 20, 50};
   int phase_idle [NUM_PHASES] = '{30, 0, 50, 25, 30, 0, 50, 25, 40, 0, 30, 25};

   initial begin : stimulus
      queue_result_type pred;
      queue_result_type typed_rsp;
      spq_req_code_type op;
      logic [31:0]      k;
      logic [15:0]      t;
      int               ph;
      int               n;
      int               left;

      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_INSERT;
      req_ch.key      <= '0;
      req_ch.tag      <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= CAP_RESET;
      reset           <= 1'b1;

      dir_tab = '{
         // empty store right after reset
         '{0, REQ_PEEK,      32'h0,         16'h0,    1, ST_EMPTY,     32'h0, 16'h0, 7'd0},
         '{0, REQ_FETCH,     32'h0,         16'h0,    1, ST_EMPTY,     32'h0, 16'h0, 7'd0},
         '{0, REQ_REMOVE,    32'h5,         16'h1,    1, ST_NOT_FOUND, 32'h0, 16'h0, 7'd0},
         '{0, REQ_EXISTS,    32'hFFFF_FFFF, 16'hFFFF, 1, ST_NOT_FOUND, 32'h0, 16'h0, 7'd0},
         // unknown codes are ignored
         '{0, REQ_UNDEF_LO,  32'h0,         16'h0,    1, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_UNDEF_HI,  32'hFFFF_FFFF, 16'hFFFF, 1, ST_OK,        32'h0, 16'h0, 7'd0},
         // extreme keys; all-ones must sort last
         '{0, REQ_INSERT,    32'hFFFF_FFFF, 16'hFFFF, 1, ST_OK,        32'h0, 16'h0, 7'd1},
         '{0, REQ_INSERT,    32'h0,         16'h0,    1, ST_OK,        32'h0, 16'h0, 7'd2},
         '{0, REQ_PEEK,      32'h0,         16'h0,    1, ST_OK,        32'h0, 16'h0, 7'd2},
         // MSB set: unsigned compare, not signed
         '{0, REQ_INSERT,    32'h8000_0000, 16'h1234, 1, ST_OK,        32'h0, 16'h0, 7'd3},
         // equal key goes in front, then a full duplicate
         '{0, REQ_INSERT,    32'h8000_0000, 16'hAAAA, 0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_INSERT,    32'h8000_0000, 16'h1234, 0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_EXISTS,    32'h8000_0000, 16'h1234, 0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_REMOVE,    32'h8000_0000, 16'h1234, 0, ST_OK,        32'h0, 16'h0, 7'd0},
         // key present, tag differs
         '{0, REQ_EXISTS,    32'h8000_0000, 16'h5555, 0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_FETCH,     32'h0,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_PEEK,      32'h0,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_UNDEF_MID, 32'h1,         16'h1,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         // capacity zero refuses every insert
         '{1, REQ_INSERT,    32'd0,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_INSERT,    32'h7,         16'h7,    1, ST_FULL,      32'h0, 16'h0, 7'd3},
         // capacity equal to the count already reached
         '{1, REQ_INSERT,    32'd3,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_INSERT,    32'h1,         16'h1,    1, ST_FULL,      32'h0, 16'h0, 7'd3},
         '{1, REQ_INSERT,    32'd4,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_INSERT,    32'h1,         16'h1,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         // capacity above the store size
         '{1, REQ_INSERT,    32'd127,       16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0},
         '{0, REQ_FETCH,     32'h0,         16'h0,    0, ST_OK,        32'h0, 16'h0, 7'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      idle_pct = 30;
      for (n = 0; n < NUM_DIR; n++) begin
         if (dir_tab[n].is_cap) begin
            write_capacity(dir_tab[n].key[6:0]);
         end else begin
            send_item(dir_tab[n].op, dir_tab[n].key, dir_tab[n].tag);
            pred = queue_apply(dir_tab[n].op, dir_tab[n].key, dir_tab[n].tag);
            if (dir_tab[n].typed) begin
               typed_rsp.status    = dir_tab[n].status;
               typed_rsp.head_key  = dir_tab[n].head_key;
               typed_rsp.head_tag  = dir_tab[n].head_tag;
               typed_rsp.occupancy = dir_tab[n].occupancy;
               expected_replies.push_back(typed_rsp);
            end else begin
               expected_replies.push_back(pred);
            end
         end
      end

      // random phases, each at its own capacity and mix
      phase_cap[NUM_PHASES - 1] = $urandom_range(0, 127);
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         write_capacity(phase_cap[ph][6:0]);
         idle_pct = phase_idle[ph];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            left = (NUM_PHASES - 1 - ph) * PHASE_ITEMS + (PHASE_ITEMS - n);
            if (left <= TAIL_ITEMS) quiet_tail = 1'b1;
            // early in the fill phase: stall the receiver so the core backs up
            if (ph == 0 && n == 40) hold_request = 1'b1;
            pick_request(phase_ins[ph], op, k, t);
            send_item(op, k, t);
            expected_replies.push_back(queue_apply(op, k, t));
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_priority_queue_core_tb OK");
      end else begin
         $display("sorted_priority_queue_core_tb NOT OK");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random ready, one long hold, check in order
   // ------------------------------------------------------------------------
   initial begin : receiver
      queue_result_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: status %0d key %h tag %h occ %0d",
                           rsp_ch.status, rsp_ch.head_key, rsp_ch.head_tag,
                           rsp_ch.occupancy);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.head_key !== want.head_key ||
                   rsp_ch.head_tag !== want.head_tag ||
                   rsp_ch.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp st %0d key %h tag %h occ %0d, ",
                               "got st %0d key %h tag %h occ %0d"},
                              want.status, want.head_key, want.head_tag, want.occupancy,
                              rsp_ch.status, rsp_ch.head_key, rsp_ch.head_tag,
                              rsp_ch.occupancy);
               end
            end
         end
         // ready only changes right after a sampled edge
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active  = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_priority_queue_core_tb NOT OK");
         $finish;
      end
   end

endmodule
